@@ hdl/utfd_pkg.sv @@
// ----------------------------------------------------------------------------
// utfd_pkg
// Shared types and constants for the UTF-16 string decoder.
// ----------------------------------------------------------------------------
package utfd_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int FIELD_W        = 24;   // width of count-type result fields
  localparam int CP_W           = 21;
  localparam int RQ_DEPTH       = 4;    // result queue entries
  localparam int APB_AW         = 5;

  localparam logic [15:0] HI_SUR_LO = 16'hD800;
  localparam logic [15:0] HI_SUR_HI = 16'hDBFF;
  localparam logic [15:0] LO_SUR_LO = 16'hDC00;
  localparam logic [15:0] LO_SUR_HI = 16'hDFFF;
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

  typedef enum logic [2:0] {
    ST_RUN        = 3'd0,
    ST_TERM       = 3'd1,
    ST_EOF        = 3'd2,
    ST_EOF_START  = 3'd3,
    ST_ZERO_LIMIT = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_LITTLE_ENDIAN  = 3'd0,
    REG_USE_TERMINATOR = 3'd1,
    REG_USE_BYTE_LIMIT = 3'd2,
    REG_USE_CHAR_LIMIT = 3'd3,
    REG_TERMINATOR_CP  = 3'd4,
    REG_BYTE_LIMIT     = 3'd5,
    REG_CHAR_LIMIT     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic              little_endian;
    logic              use_terminator;
    logic              use_byte_limit;
    logic              use_char_limit;
    logic [CP_W-1:0]   terminator_code_point;
    logic [FIELD_W-1:0] byte_limit;
    logic [FIELD_W-1:0] char_limit;
  } cfg_t;

  typedef struct packed {
    logic               has_char;
    logic [CP_W-1:0]    code_point;
    logic [FIELD_W-1:0] char_index;
    status_t            end_status;
    logic [FIELD_W-1:0] bytes_consumed;
    logic [FIELD_W-1:0] non_bmp_count;
    logic               last;
  } res_t;

endpackage

@@ hdl/utfd_in_if.sv @@
// ----------------------------------------------------------------------------
// utfd_in_if
// Byte channel into the decoder: valid/ready plus one raw byte and flags.
// ----------------------------------------------------------------------------
interface utfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;
  logic       final_req;

  modport source (output valid, data_byte, first, final_req, input ready);
  modport sink   (input valid, data_byte, first, final_req, output ready);
endinterface

@@ hdl/utfd_out_if.sv @@
// ----------------------------------------------------------------------------
// utfd_out_if
// Result channel out of the decoder: valid/ready plus one decoded result.
// ----------------------------------------------------------------------------
interface utfd_out_if;
  logic        valid;
  logic        ready;
  logic        has_char;
  logic [20:0] code_point;
  logic [23:0] char_index;
  logic [2:0]  end_status;
  logic [23:0] bytes_consumed;
  logic [23:0] non_bmp_count;
  logic        last;

  modport source (output valid, has_char, code_point, char_index, end_status,
                  bytes_consumed, non_bmp_count, last, input ready);
  modport sink   (input valid, has_char, code_point, char_index, end_status,
                  bytes_consumed, non_bmp_count, last, output ready);
endinterface

@@ hdl/utfd_core.sv @@
// ----------------------------------------------------------------------------
// utfd_core
// Per-byte decode step: unit assembly, surrogate pairing, limits and status.
// ----------------------------------------------------------------------------
module utfd_core
  import utfd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        fire,
  input  logic [7:0]  data_byte,
  input  logic        first,
  input  logic        final_req,
  output logic [1:0]  push_cnt,
  output res_t        res0,
  output res_t        res1
);

  localparam int CB = COUNT_BITS;
  localparam int WI = (CB > FIELD_W) ? CB : FIELD_W;
  localparam int WB = (CB + 1 > FIELD_W) ? CB + 1 : FIELD_W;

  logic          byte_phase_r, byte_phase_nxt;
  logic [7:0]    held_byte_r, held_byte_nxt;
  logic [15:0]   pending_high_r, pending_high_nxt;
  logic          pending_valid_r, pending_valid_nxt;
  logic [CB-1:0] units_used_r, units_used_nxt;
  logic [CB-1:0] chars_done_r, chars_done_nxt;
  logic [CB-1:0] pairs_done_r, pairs_done_nxt;
  logic          string_done_r, string_done_nxt;

  logic [15:0]     unit;
  logic [CP_W-1:0] pair_cp;
  logic            zero_limit;
  logic            do_unit;
  logic [1:0]      n;
  res_t            r0, r1, e;

  function automatic logic [FIELD_W-1:0] to_field(logic [CB-1:0] x);
    logic [WI-1:0] t;
    t = WI'(x);
    return t[FIELD_W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] to_bytes(logic [CB-1:0] x);
    logic [WB-1:0] t;
    t = WB'(x) << 1;
    return t[FIELD_W-1:0];
  endfunction

  function automatic res_t mk_char(logic [CP_W-1:0] cp, logic [CB-1:0] u_new,
                                   logic [CB-1:0] c_idx, logic [CB-1:0] c_new,
                                   logic [CB-1:0] p, logic eof_forced,
                                   logic fin, cfg_t cf);
    res_t r;
    logic hit;
    hit = (cf.use_terminator && (cp == cf.terminator_code_point)) ||
          (cf.use_byte_limit && (WI'(u_new) >= WI'(cf.byte_limit[FIELD_W-1:1]))) ||
          (cf.use_char_limit && (WI'(c_new) >= WI'(cf.char_limit)));
    r.has_char       = 1'b1;
    r.code_point     = cp;
    r.char_index     = to_field(c_idx);
    r.end_status     = eof_forced ? ST_EOF : hit ? ST_TERM : fin ? ST_EOF : ST_RUN;
    r.bytes_consumed = to_bytes(u_new);
    r.non_bmp_count  = to_field(p);
    r.last           = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_empty(status_t st, logic [CB-1:0] u, logic [CB-1:0] p);
    res_t r;
    r                = '0;
    r.end_status     = st;
    r.bytes_consumed = to_bytes(u);
    r.non_bmp_count  = to_field(p);
    return r;
  endfunction

  assign unit    = cfg.little_endian ? {data_byte, held_byte_r} : {held_byte_r, data_byte};
  assign pair_cp = SUPP_BASE + CP_W'({pending_high_r[9:0], unit[9:0]});
  assign zero_limit = (cfg.use_char_limit && (cfg.char_limit == '0)) ||
                      (cfg.use_byte_limit && (cfg.byte_limit < FIELD_W'(2)));

  always_comb begin
    byte_phase_nxt    = byte_phase_r;
    held_byte_nxt     = held_byte_r;
    pending_high_nxt  = pending_high_r;
    pending_valid_nxt = pending_valid_r;
    units_used_nxt    = units_used_r;
    chars_done_nxt    = chars_done_r;
    pairs_done_nxt    = pairs_done_r;
    string_done_nxt   = string_done_r;
    r0      = '0;
    r1      = '0;
    e       = '0;
    n       = 2'd0;
    do_unit = 1'b0;

    if (fire) begin
      if (first) begin
        byte_phase_nxt    = 1'b0;
        held_byte_nxt     = '0;
        pending_high_nxt  = '0;
        pending_valid_nxt = 1'b0;
        units_used_nxt    = '0;
        chars_done_nxt    = '0;
        pairs_done_nxt    = '0;
        string_done_nxt   = zero_limit;
        if (zero_limit) begin
          r0 = mk_empty(ST_ZERO_LIMIT, '0, '0);
          n  = 2'd1;
        end
      end

      if (!string_done_nxt) begin
        if (!byte_phase_nxt) begin
          if (!final_req) begin
            held_byte_nxt  = data_byte;
            byte_phase_nxt = 1'b1;
          end else if (pending_valid_nxt) begin
            // waiting high surrogate flushed alone at eof
            pending_valid_nxt = 1'b0;
            r0 = mk_char(CP_W'(pending_high_nxt), units_used_nxt + CB'(1),
                         chars_done_nxt, chars_done_nxt + CB'(1), pairs_done_nxt,
                         1'b1, 1'b1, cfg);
            units_used_nxt  = units_used_nxt + CB'(1);
            chars_done_nxt  = chars_done_nxt + CB'(1);
            string_done_nxt = 1'b1;
            n = 2'd1;
          end else begin
            r0 = mk_empty((units_used_nxt == '0) ? ST_EOF_START : ST_EOF,
                          units_used_nxt, pairs_done_nxt);
            string_done_nxt = 1'b1;
            n = 2'd1;
          end
        end else begin
          byte_phase_nxt = 1'b0;
          do_unit        = 1'b1;
          if (pending_valid_nxt) begin
            pending_valid_nxt = 1'b0;
            if (unit >= LO_SUR_LO && unit <= LO_SUR_HI) begin
              pairs_done_nxt = pairs_done_nxt + CB'(1);
              r0 = mk_char(pair_cp, units_used_nxt + CB'(2), chars_done_nxt,
                           chars_done_nxt + CB'(1), pairs_done_nxt, 1'b0, final_req, cfg);
              units_used_nxt = units_used_nxt + CB'(2);
              chars_done_nxt = chars_done_nxt + CB'(1);
              if (r0.end_status != ST_RUN) string_done_nxt = 1'b1;
              n = 2'd1;
              do_unit = 1'b0;
            end else begin
              // lone high surrogate, then this unit on its own
              r0 = mk_char(CP_W'(pending_high_nxt), units_used_nxt + CB'(1),
                           chars_done_nxt, chars_done_nxt + CB'(1), pairs_done_nxt,
                           1'b0, 1'b0, cfg);
              units_used_nxt = units_used_nxt + CB'(1);
              chars_done_nxt = chars_done_nxt + CB'(1);
              n = 2'd1;
              if (r0.end_status != ST_RUN) begin
                string_done_nxt = 1'b1;
                do_unit = 1'b0;
              end
            end
          end

          if (do_unit) begin
            if (unit >= HI_SUR_LO && unit <= HI_SUR_HI &&
                !(final_req || (cfg.use_byte_limit &&
                  (WI'(units_used_nxt + CB'(1)) >= WI'(cfg.byte_limit[FIELD_W-1:1]))))) begin
              pending_high_nxt  = unit;
              pending_valid_nxt = 1'b1;
            end else begin
              e = mk_char(CP_W'(unit), units_used_nxt + CB'(1), chars_done_nxt,
                          chars_done_nxt + CB'(1), pairs_done_nxt,
                          (unit >= HI_SUR_LO && unit <= HI_SUR_HI), final_req, cfg);
              units_used_nxt = units_used_nxt + CB'(1);
              chars_done_nxt = chars_done_nxt + CB'(1);
              if (e.end_status != ST_RUN) string_done_nxt = 1'b1;
              if (n == 2'd0) r0 = e;
              else r1 = e;
              n = n + 2'd1;
            end
          end
        end
      end

      if (n == 2'd2) r1.last = 1'b1;
      else r0.last = 1'b1;
    end
  end

  assign push_cnt = n;
  assign res0     = r0;
  assign res1     = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_phase_r    <= 1'b0;
      held_byte_r     <= '0;
      pending_high_r  <= '0;
      pending_valid_r <= 1'b0;
      units_used_r    <= '0;
      chars_done_r    <= '0;
      pairs_done_r    <= '0;
      string_done_r   <= 1'b1;
    end else begin
      byte_phase_r    <= byte_phase_nxt;
      held_byte_r     <= held_byte_nxt;
      pending_high_r  <= pending_high_nxt;
      pending_valid_r <= pending_valid_nxt;
      units_used_r    <= units_used_nxt;
      chars_done_r    <= chars_done_nxt;
      pairs_done_r    <= pairs_done_nxt;
      string_done_r   <= string_done_nxt;
    end
  end

`ifndef SYNTH
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !first && string_done_r |-> push_cnt == 2'd0)
    else $error("result produced while no string is open");

  a_two_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt == 2'd2 |-> pending_valid_r && byte_phase_r)
    else $error("two results without a waiting high surrogate");

  a_zero_limit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    fire && first && zero_limit |=> string_done_r)
    else $error("zero limit did not end the string");
`endif

endmodule

@@ hdl/utfd_rq.sv @@
// ----------------------------------------------------------------------------
// utfd_rq
// Small result queue: takes up to two results a cycle, hands out one a beat.
// ----------------------------------------------------------------------------
module utfd_rq
  import utfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  res_t       res0,
  input  res_t       res1,
  output logic       space_ok,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res
);

  localparam int PW = $clog2(RQ_DEPTH);

  res_t          mem_r [RQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  // room for a worst-case step of two results
  assign space_ok  = (count_r <= (PW+1)'(RQ_DEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + PW'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + PW'(pop);
  assign count_nxt  = count_r + (PW+1)'(push_cnt) - (PW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wr_ptr_r] <= res0;
    if (push_cnt == 2'd2) mem_r[wr_ptr_r + PW'(1)] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PW+1)'(RQ_DEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd0 |-> space_ok)
    else $error("push without room in result queue");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("result beat changed while stalled");
`endif

endmodule

@@ hdl/utf16_string_decoder_top.sv @@
// ----------------------------------------------------------------------------
// utf16_string_decoder_top
// UTF-16 byte stream decoder with APB register block and result queue.
// ----------------------------------------------------------------------------
// Channel   Dir   Beat contents
// in_ch     in    data_byte, first, final_req
// out_ch    out   has_char, code_point, char_index, end_status,
//                 bytes_consumed, non_bmp_count, last
// cfg (APB) in    register writes/reads, 4-byte stride, always ready
//
// One byte per cycle if ready; its results sit in a 4-entry queue and show on
// out_ch from the next cycle. A byte that flushes a lone high surrogate makes
// two results, sent over two out beats. in_ch.ready is high while at most two
// results wait, so a stalled out_ch stops the input at three or four waiting.
// rst_n is synchronous; after reset no string is open until a first byte.
// ----------------------------------------------------------------------------
module utf16_string_decoder_top
  import utfd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  utfd_in_if.sink           in_ch,
  utfd_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t       cfg_r;
  reg_idx_t   reg_idx;
  logic       cfg_wr;
  logic       in_fire;
  logic       space_ok;
  logic [1:0] push_cnt;
  res_t       res0, res1, out_res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.little_endian         <= 1'b1;
      cfg_r.use_terminator        <= 1'b1;
      cfg_r.use_byte_limit        <= 1'b0;
      cfg_r.use_char_limit        <= 1'b0;
      cfg_r.terminator_code_point <= '0;
      cfg_r.byte_limit            <= '0;
      cfg_r.char_limit            <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LITTLE_ENDIAN:  cfg_r.little_endian         <= pwdata[0];
        REG_USE_TERMINATOR: cfg_r.use_terminator        <= pwdata[0];
        REG_USE_BYTE_LIMIT: cfg_r.use_byte_limit        <= pwdata[0];
        REG_USE_CHAR_LIMIT: cfg_r.use_char_limit        <= pwdata[0];
        REG_TERMINATOR_CP:  cfg_r.terminator_code_point <= pwdata[CP_W-1:0];
        REG_BYTE_LIMIT:     cfg_r.byte_limit            <= pwdata[FIELD_W-1:0];
        REG_CHAR_LIMIT:     cfg_r.char_limit            <= pwdata[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LITTLE_ENDIAN:  prdata = 32'(cfg_r.little_endian);
      REG_USE_TERMINATOR: prdata = 32'(cfg_r.use_terminator);
      REG_USE_BYTE_LIMIT: prdata = 32'(cfg_r.use_byte_limit);
      REG_USE_CHAR_LIMIT: prdata = 32'(cfg_r.use_char_limit);
      REG_TERMINATOR_CP:  prdata = 32'(cfg_r.terminator_code_point);
      REG_BYTE_LIMIT:     prdata = 32'(cfg_r.byte_limit);
      REG_CHAR_LIMIT:     prdata = 32'(cfg_r.char_limit);
      default:            prdata = '0;
    endcase
  end

  assign in_ch.ready = space_ok;
  assign in_fire     = in_ch.valid && space_ok;

  utfd_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .fire      (in_fire),
    .data_byte (in_ch.data_byte),
    .first     (in_ch.first),
    .final_req (in_ch.final_req),
    .push_cnt  (push_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  utfd_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .res0      (res0),
    .res1      (res1),
    .space_ok  (space_ok),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.has_char       = out_res.has_char;
  assign out_ch.code_point     = out_res.code_point;
  assign out_ch.char_index     = out_res.char_index;
  assign out_ch.end_status     = out_res.end_status;
  assign out_ch.bytes_consumed = out_res.bytes_consumed;
  assign out_ch.non_bmp_count  = out_res.non_bmp_count;
  assign out_ch.last           = out_res.last;

endmodule

@@ tb/sv/tb_utf16_string_decoder_top.sv @@
// ----------------------------------------------------------------------------
// tb_utf16_string_decoder_top
// Self-checking bench for the UTF-16 string decoder. Drives byte beats and
// register writes, predicts every result beat in a scoreboard and compares
// field by field, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_utf16_string_decoder_top;
  import utfd_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 4;
  localparam int TARGET_ITEMS  = 1900;
  localparam int PHASE_BYTES   = 150;
  localparam int HOLD_CYCLES   = 200;
  localparam int CYCLE_LIMIT   = 1_000_000;

  // {final_req, first, data_byte}
  localparam logic [9:0] DIRECTED_BYTES [25] = '{
    10'h05A,                                  // no string open: dropped
    10'h3C3,                                  // first and final together
    10'h141, 10'h000, 10'h0FF, 10'h0FF,       // 'A', U+FFFF
    10'h03D, 10'h0D8, 10'h000, 10'h0DE,       // surrogate pair
    10'h000, 10'h0D8, 10'h041, 10'h000,       // lone high, then 'A'
    10'h27F,                                  // odd trailing byte at eof
    10'h100, 10'h2DB,                         // high surrogate at eof
    10'h100, 10'h000, 10'h012,                // terminator, trailing byte
    10'h1FF, 10'h0DB, 10'h280,                // pending high, odd eof byte
    10'h100, 10'h200                          // terminator on the eof unit
  };

  class decode_scoreboard;
    cfg_t        cfg;
    logic        byte_phase;
    logic [7:0]  held_byte;
    logic [15:0] pend_high;
    logic        pend_valid;
    logic [23:0] units_used;
    logic [23:0] chars_done;
    logic [23:0] pairs_done;
    logic        string_done;
    res_t        expected_q[$];
    int          step_results;
    int          errors;
    int          checked;
    int          status_hits[5];

    function new();
      cfg = '0;
      cfg.little_endian  = 1'b1;
      cfg.use_terminator = 1'b1;
      byte_phase  = 1'b0;
      held_byte   = '0;
      pend_high   = '0;
      pend_valid  = 1'b0;
      units_used  = '0;
      chars_done  = '0;
      pairs_done  = '0;
      string_done = 1'b1;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_LITTLE_ENDIAN:  cfg.little_endian = v[0];
        REG_USE_TERMINATOR: cfg.use_terminator = v[0];
        REG_USE_BYTE_LIMIT: cfg.use_byte_limit = v[0];
        REG_USE_CHAR_LIMIT: cfg.use_char_limit = v[0];
        REG_TERMINATOR_CP:  cfg.terminator_code_point = v[CP_W-1:0];
        REG_BYTE_LIMIT:     cfg.byte_limit = v[FIELD_W-1:0];
        REG_CHAR_LIMIT:     cfg.char_limit = v[FIELD_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function string show(res_t r);
      return $sformatf("has=%0b cp=%06h idx=%0d st=%0d bytes=%0d pairs=%0d last=%0b",
                       r.has_char, r.code_point, r.char_index, r.end_status,
                       r.bytes_consumed, r.non_bmp_count, r.last);
    endfunction

    function void push(logic has, logic [CP_W-1:0] cp, logic [23:0] idx, status_t st);
      res_t r;
      r.has_char       = has;
      r.code_point     = cp;
      r.char_index     = idx;
      r.end_status     = st;
      r.bytes_consumed = {units_used[22:0], 1'b0};
      r.non_bmp_count  = pairs_done;
      r.last           = 1'b0;
      expected_q.push_back(r);
      step_results++;
    endfunction

    function void emit_char(logic [CP_W-1:0] cp, int nunits, bit eof_forced, bit fin);
      logic [23:0] idx;
      status_t     st;
      idx        = chars_done;
      units_used = units_used + 24'(nunits);
      chars_done = chars_done + 24'd1;
      st = ST_RUN;
      if (eof_forced)
        st = ST_EOF;
      else if ((cfg.use_terminator && cp == cfg.terminator_code_point) ||
               (cfg.use_byte_limit && units_used >= (cfg.byte_limit >> 1)) ||
               (cfg.use_char_limit && chars_done >= cfg.char_limit))
        st = ST_TERM;
      else if (fin)
        st = ST_EOF;
      if (st != ST_RUN) string_done = 1'b1;
      push(1'b1, cp, idx, st);
    endfunction

    function void mark_last();
      if (step_results > 0) expected_q[expected_q.size()-1].last = 1'b1;
    endfunction

    // Returns 1 when the beat took part in a string, 0 when it was dropped.
    function bit note_byte(logic [7:0] b, bit first, bit fin);
      logic [15:0] unit;
      logic [23:0] next_units;
      step_results = 0;
      if (first) begin
        byte_phase  = 1'b0;
        held_byte   = '0;
        pend_high   = '0;
        pend_valid  = 1'b0;
        units_used  = '0;
        chars_done  = '0;
        pairs_done  = '0;
        string_done = 1'b0;
        if ((cfg.use_char_limit && cfg.char_limit == 0) ||
            (cfg.use_byte_limit && cfg.byte_limit < 2)) begin
          string_done = 1'b1;
          push(1'b0, '0, '0, ST_ZERO_LIMIT);
          mark_last();
          return 1'b1;
        end
      end
      if (string_done) return 1'b0;

      if (!byte_phase) begin
        if (!fin) begin
          held_byte  = b;
          byte_phase = 1'b1;
          return 1'b1;
        end
        // half a unit at eof is dropped
        if (pend_valid) begin
          pend_valid = 1'b0;
          emit_char(CP_W'(pend_high), 1, 1'b1, 1'b1);
        end else begin
          push(1'b0, '0, '0, (units_used == 0) ? ST_EOF_START : ST_EOF);
          string_done = 1'b1;
        end
        mark_last();
        return 1'b1;
      end

      byte_phase = 1'b0;
      unit = cfg.little_endian ? {b, held_byte} : {held_byte, b};

      if (pend_valid) begin
        pend_valid = 1'b0;
        if (unit >= LO_SUR_LO && unit <= LO_SUR_HI) begin
          pairs_done = pairs_done + 24'd1;
          emit_char(SUPP_BASE + (CP_W'(pend_high - HI_SUR_LO) << 10) +
                    CP_W'(unit - LO_SUR_LO), 2, 1'b0, fin);
          mark_last();
          return 1'b1;
        end
        emit_char(CP_W'(pend_high), 1, 1'b0, 1'b0);
        if (string_done) begin
          mark_last();
          return 1'b1;
        end
      end

      if (unit >= HI_SUR_LO && unit <= HI_SUR_HI) begin
        next_units = units_used + 24'd1;
        if (fin || (cfg.use_byte_limit && next_units >= (cfg.byte_limit >> 1)))
          emit_char(CP_W'(unit), 1, 1'b1, 1'b1);
        else begin
          pend_high  = unit;
          pend_valid = 1'b1;
        end
      end else begin
        emit_char(CP_W'(unit), 1, 1'b0, fin);
      end
      mark_last();
      return 1'b1;
    endfunction

    function void check_result(res_t got);
      res_t  want;
      string diff;
      if (expected_q.size() == 0) begin
        note_error({"result beat with nothing expected: ", show(got)});
        return;
      end
      want = expected_q.pop_front();
      checked++;
      status_hits[int'(want.end_status)]++;
      diff = "";
      if (got.has_char !== want.has_char)             diff = {diff, " has_char"};
      if (got.code_point !== want.code_point)         diff = {diff, " code_point"};
      if (got.char_index !== want.char_index)         diff = {diff, " char_index"};
      if (got.end_status !== want.end_status)         diff = {diff, " end_status"};
      if (got.bytes_consumed !== want.bytes_consumed) diff = {diff, " bytes_consumed"};
      if (got.non_bmp_count !== want.non_bmp_count)   diff = {diff, " non_bmp_count"};
      if (got.last !== want.last)                     diff = {diff, " last"};
      if (diff != "")
        note_error($sformatf("beat %0d wrong%s: expected %s, got %s",
                             checked, diff, show(want), show(got)));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  utfd_in_if  in_ch();
  utfd_out_if out_ch();

  utf16_string_decoder_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  decode_scoreboard sb = new();

  res_t        out_beat;
  int unsigned cycle_cnt = 0;
  int          sink_hold = 0;
  bit          sink_always_ready = 1'b0;
  bit          src_quiet = 1'b0;
  int          live_items = 0;
  int          bytes_sent = 0;
  int          phase = 0;

  always #(CLK_PERIOD/2) clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("ERROR: no progress after %0d cycles", CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  always_comb begin
    out_beat.has_char       = out_ch.has_char;
    out_beat.code_point     = out_ch.code_point;
    out_beat.char_index     = out_ch.char_index;
    out_beat.end_status     = status_t'(out_ch.end_status);
    out_beat.bytes_consumed = out_ch.bytes_consumed;
    out_beat.non_bmp_count  = out_ch.non_bmp_count;
    out_beat.last           = out_ch.last;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_beat);
  end

  // Result sink: random stalls, always-ready stretches, and forced hold-offs.
  initial begin
    int r;
    int stall_left;
    out_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ch.ready = 1'b0;
      end else if (sink_hold > 0) begin
        out_ch.ready = 1'b0;
        sink_hold--;
      end else if (sink_always_ready) begin
        out_ch.ready = 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          out_ch.ready = 1'b1;
        end else begin
          out_ch.ready = 1'b0;
          stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit first, input bit fin);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    gap = src_quiet ? 0 : (r < 72) ? 0 : (r < 95) ? $urandom_range(1, 3) :
                                                     $urandom_range(8, 40);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid     = 1'b0;
      in_ch.data_byte = 8'($urandom);
      in_ch.first     = 1'($urandom);
      in_ch.final_req = 1'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.data_byte = b;
    in_ch.first     = first;
    in_ch.final_req = fin;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    if (sb.note_byte(b, first, fin)) live_items++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] want;
    case (idx)
      REG_TERMINATOR_CP: want = val & 32'h001F_FFFF;
      REG_BYTE_LIMIT,
      REG_CHAR_LIMIT:    want = val & 32'h00FF_FFFF;
      default:           want = {31'd0, val[0]};
    endcase
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      sb.note_error($sformatf("register %s reads %h, expected %h", idx.name(), prdata, want));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apply_config(input bit le, input bit ut, input bit ub, input bit uc,
                              input logic [20:0] tp, input logic [23:0] bl,
                              input logic [23:0] cl);
    reg_write(REG_LITTLE_ENDIAN, {31'd0, le});
    reg_write(REG_USE_TERMINATOR, {31'd0, ut});
    reg_write(REG_USE_BYTE_LIMIT, {31'd0, ub});
    reg_write(REG_USE_CHAR_LIMIT, {31'd0, uc});
    reg_write(REG_TERMINATOR_CP, {11'd0, tp});
    reg_write(REG_BYTE_LIMIT, {8'd0, bl});
    reg_write(REG_CHAR_LIMIT, {8'd0, cl});
  endtask

  // One string of random units, mostly well formed, sometimes cut short.
  task automatic send_string();
    logic [15:0] units[$];
    logic [7:0]  bytes_q[$];
    logic [15:0] u;
    logic [20:0] sup;
    int          n;
    int          kind;
    int          tail;
    bit          swap;
    bit          odd;
    bit          fin_last;
    bit          f;
    bit          fn;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    repeat (n) begin
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        units.push_back(16'($urandom_range(1, 127)));
      end else if (kind < 50) begin
        u = 16'($urandom);
        if (u >= HI_SUR_LO && u <= LO_SUR_HI) u = u & 16'h7FFF;
        units.push_back(u);
      end else if (kind < 65) begin
        units.push_back(16'($urandom_range(HI_SUR_LO, HI_SUR_HI)));
        units.push_back(16'($urandom_range(LO_SUR_LO, LO_SUR_HI)));
      end else if (kind < 73) begin
        units.push_back(16'($urandom_range(HI_SUR_LO, HI_SUR_HI)));
      end else if (kind < 80) begin
        units.push_back(16'($urandom_range(LO_SUR_LO, LO_SUR_HI)));
      end else if (kind < 90) begin
        if (sb.cfg.terminator_code_point >= SUPP_BASE) begin
          sup = sb.cfg.terminator_code_point - SUPP_BASE;
          units.push_back(HI_SUR_LO + 16'(sup[19:10]));
          units.push_back(LO_SUR_LO + 16'(sup[9:0]));
        end else begin
          units.push_back(sb.cfg.terminator_code_point[15:0]);
        end
      end else begin
        units.push_back(16'($urandom));
      end
    end
    swap = ($urandom_range(0, 19) == 0);
    foreach (units[i]) begin
      if (sb.cfg.little_endian ^ swap) begin
        bytes_q.push_back(units[i][7:0]);
        bytes_q.push_back(units[i][15:8]);
      end else begin
        bytes_q.push_back(units[i][15:8]);
        bytes_q.push_back(units[i][7:0]);
      end
    end
    tail = $urandom_range(0, 99);
    odd = (tail >= 70 && tail < 82) || tail >= 96 || bytes_q.size() == 0;
    fin_last = (tail < 82);
    if (odd) bytes_q.push_back(8'($urandom));

    if ($urandom_range(0, 99) < 8)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom));

    foreach (bytes_q[i]) begin
      f  = (i == 0) || ($urandom_range(0, 59) == 0);
      fn = (i == bytes_q.size() - 1) ? fin_last : ($urandom_range(0, 79) == 0);
      send_byte(bytes_q[i], f, fn);
    end
  endtask

  initial begin
    bit          le;
    bit          ut;
    bit          ub;
    bit          uc;
    logic [20:0] tp;
    logic [23:0] bl;
    logic [23:0] cl;
    int          r;
    int          phase_start;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.first     = 1'b0;
    in_ch.final_req = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed beats run on the reset configuration
    foreach (DIRECTED_BYTES[i])
      send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8], DIRECTED_BYTES[i][9]);
    drain_results();

    while (bytes_sent < TARGET_ITEMS) begin
      case (phase)
        0: apply_config(1'b0, 1'b0, 1'b0, 1'b0, 21'h10FFFF, 24'hFFFFFF, 24'hFFFFFF);
        1: apply_config(1'b1, 1'b1, 1'b1, 1'b0, 21'h0, 24'd1, 24'd0);
        2: apply_config(1'b0, 1'b0, 1'b0, 1'b1, 21'h0, 24'd0, 24'd0);
        3: apply_config(1'b1, 1'b1, 1'b1, 1'b1, 21'h10000, 24'hFFFFFF, 24'hFFFFFF);
        4: apply_config(1'b1, 1'b0, 1'b1, 1'b0, 21'h0, 24'd2, 24'd0);
        5: apply_config(1'b0, 1'b1, 1'b0, 1'b1, 21'h41, 24'd0, 24'd1);
        6: apply_config(1'b1, 1'b0, 1'b1, 1'b0, 21'h0, 24'd7, 24'd0);
        default: begin
          le = 1'($urandom);
          ut = 1'($urandom);
          ub = 1'($urandom);
          uc = 1'($urandom);
          r = $urandom_range(0, 3);
          tp = (r == 0) ? 21'h0 :
               (r == 1) ? 21'($urandom_range(1, 127)) :
               (r == 2) ? 21'($urandom_range(0, 16'hFFFF)) :
                          21'($urandom_range(21'h10000, 21'h10FFFF));
          r = $urandom_range(0, 99);
          bl = (r < 8) ? 24'($urandom_range(0, 1)) :
               (r < 80) ? 24'($urandom_range(2, 50)) : 24'($urandom_range(51, 24'hFFFFFF));
          r = $urandom_range(0, 99);
          cl = (r < 5) ? 24'd0 :
               (r < 85) ? 24'($urandom_range(1, 25)) : 24'($urandom_range(26, 24'hFFFFFF));
          apply_config(le, ut, ub, uc, tp, bl, cl);
        end
      endcase

      @(posedge clk);
      src_quiet = (phase % 4 == 2);
      sink_always_ready = (phase % 4 == 3);
      // long sink hold-off while the source keeps pushing beats back to back
      if (phase % 5 == 3) begin
        src_quiet = 1'b1;
        sink_hold = HOLD_CYCLES;
      end

      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        send_string();
        if ($urandom_range(0, 99) < 3) drain_results();
      end
      drain_results();
      phase++;
    end

    drain_results();
    $display("Ran %0d input beats (%0d inside strings) over %0d register settings;",
             bytes_sent, live_items, phase + 1);
    $display("%0d result beats checked, status mix run/term/eof/eof-at-start/zero-limit: %0d/%0d/%0d/%0d/%0d",
             sb.checked, sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
             sb.status_hits[3], sb.status_hits[4]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (sb.expected_q.size() != 0)
        $display("ERROR: %0d expected result beats never arrived", sb.expected_q.size());
      $display("%0d mismatches in total", sb.errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
